/* rtl/core/p2p1_triangle_element_matrices_core_defines.svh */
// ----------------------------------------------------------------------------
// p2p1 element matrices core assertion macros
// Shared property wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef P2P1_TRIANGLE_ELEMENT_MATRICES_CORE_DEFINES_SVH
`define P2P1_TRIANGLE_ELEMENT_MATRICES_CORE_DEFINES_SVH

// same-cycle implication
`define P2P1_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("p2p1 core check failed");

// next-cycle implication
`define P2P1_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("p2p1 core check failed");

`endif

/* rtl/core/p2p1em_pkg.sv */
// ----------------------------------------------------------------------------
// p2p1em_pkg
// Types, codes and basis tables of the triangle element matrices core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package p2p1em_pkg;

   localparam logic [1:0] KIND_VISC = 2'd0;
   localparam logic [1:0] KIND_DIV  = 2'd1;
   localparam logic [1:0] KIND_LOAD = 2'd2;

   localparam logic [1:0] REG_VISCOSITY = 2'd0;
   localparam logic [1:0] REG_FORCE_X   = 2'd1;
   localparam logic [1:0] REG_FORCE_Y   = 2'd2;

   localparam logic [31:0] RESET_VISCOSITY = 32'h0001_0000;
   localparam logic [31:0] RESET_FORCE     = 32'h0001_0000;

   localparam logic [47:0] VAL_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] VAL_NEG_MIN = 48'h8000_0000_0000;

   localparam int DIV_BITS = 48;

   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
      logic signed [32:0] c;
      logic signed [32:0] d;
      logic [65:0]        absd;
      logic               negd;
      logic               degen;
   } elem_type;

   // six times the reference gradients, x and y parts, per point and node
   localparam logic signed [5:0] G0_TAB [0:2][0:5] = '{
      '{-6'sd10, -6'sd2, 6'sd0,  6'sd12, 6'sd4,  -6'sd4},
      '{ 6'sd2,  6'sd10, 6'sd0, -6'sd12, 6'sd4,  -6'sd4},
      '{ 6'sd2,  -6'sd2, 6'sd0,  6'sd0,  6'sd16, -6'sd16}
   };
   localparam logic signed [5:0] G1_TAB [0:2][0:5] = '{
      '{-6'sd10, 6'sd0, -6'sd2,  -6'sd4,  6'sd4,  6'sd12},
      '{ 6'sd2,  6'sd0, -6'sd2, -6'sd16,  6'sd16, 6'sd0},
      '{ 6'sd2,  6'sd0,  6'sd10, -6'sd4,  6'sd4, -6'sd12}
   };

   // 36 times the summed quadratic basis values per node
   localparam logic [5:0] PHIS_TAB [0:5] = '{6'd0, 6'd0, 6'd0, 6'd36, 6'd36, 6'd36};

   function automatic logic signed [38:0] gmix(input logic signed [32:0] p,
                                              input logic signed [32:0] r,
                                              input logic signed [5:0]  gp,
                                              input logic signed [5:0]  gr);
      return 39'(p) * 39'(gp) - 39'(r) * 39'(gr);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/p2p1em_front.sv */
// ----------------------------------------------------------------------------
// p2p1em_front
// Edge vectors and determinant pipeline feeding a short element queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2p1em_front
   import p2p1em_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [31:0] req_corner0_x,
   input  wire logic signed [31:0] req_corner0_y,
   input  wire logic signed [31:0] req_corner1_x,
   input  wire logic signed [31:0] req_corner1_y,
   input  wire logic signed [31:0] req_corner2_x,
   input  wire logic signed [31:0] req_corner2_y,
   input  wire logic               q_pop,
   output logic                    q_empty,
   output elem_type                q_head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1) + 1;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [32:0] a1_ff, a1_in, b1_ff, b1_in, c1_ff, c1_in, d1_ff, d1_in;
   logic signed [32:0] a2_ff, a2_in, b2_ff, b2_in, c2_ff, c2_in, d2_ff, d2_in;
   logic signed [65:0] pad_ff, pad_in, pbc_ff, pbc_in;
   logic signed [32:0] a3_ff, a3_in, b3_ff, b3_in, c3_ff, c3_in, d3_ff, d3_in;
   logic signed [66:0] det_ff, det_in;
   elem_type mem_ff [0:DEPTH-1];
   elem_type wr_elem;
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in, occ;
   logic accept, do_pop;

   assign occ = cnt_ff + CW'(v1_ff) + CW'(v2_ff) + CW'(v3_ff);
   assign req_full = occ >= CW'(DEPTH);
   assign accept = req_push & ~req_full;
   assign q_empty = cnt_ff == '0;
   assign q_head = mem_ff[rp_ff];
   assign do_pop = q_pop & ~q_empty;

   always_comb begin
      v1_in = accept;
      a1_in = 33'(req_corner1_x) - 33'(req_corner0_x);
      c1_in = 33'(req_corner1_y) - 33'(req_corner0_y);
      b1_in = 33'(req_corner2_x) - 33'(req_corner0_x);
      d1_in = 33'(req_corner2_y) - 33'(req_corner0_y);
      v2_in = v1_ff;
      pad_in = 66'(a1_ff) * 66'(d1_ff);
      pbc_in = 66'(b1_ff) * 66'(c1_ff);
      a2_in = a1_ff;
      b2_in = b1_ff;
      c2_in = c1_ff;
      d2_in = d1_ff;
      v3_in = v2_ff;
      det_in = 67'(pad_ff) - 67'(pbc_ff);
      a3_in = a2_ff;
      b3_in = b2_ff;
      c3_in = c2_ff;
      d3_in = d2_ff;
      wr_elem.a = a3_ff;
      wr_elem.b = b3_ff;
      wr_elem.c = c3_ff;
      wr_elem.d = d3_ff;
      wr_elem.negd = det_ff[66];
      wr_elem.absd = det_ff[66] ? 66'(-det_ff) : 66'(det_ff);
      wr_elem.degen = det_ff == '0;
      wp_in = v3_ff ? ((wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in = do_pop ? ((rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + CW'(v3_ff) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      a1_ff <= a1_in;
      b1_ff <= b1_in;
      c1_ff <= c1_in;
      d1_ff <= d1_in;
      pad_ff <= pad_in;
      pbc_ff <= pbc_in;
      a2_ff <= a2_in;
      b2_ff <= b2_in;
      c2_ff <= c2_in;
      d2_ff <= d2_in;
      det_ff <= det_in;
      a3_ff <= a3_in;
      b3_ff <= b3_in;
      c3_ff <= c3_in;
      d3_ff <= d3_in;
      if (v3_ff) begin
         mem_ff[wp_ff] <= wr_elem;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/p2p1em_div.sv */
// ----------------------------------------------------------------------------
// p2p1em_div
// Bit-serial rounding divider with Q24.24 saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2p1em_div
   import p2p1em_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] num,
   input  wire logic [71:0]  den,
   input  wire logic         neg,
   output logic              done,
   output logic [47:0]       value
);

   logic [127:0] n2;
   logic [72:0]  d2;
   logic         sat;
   logic [72:0]  r_ff, r_in, d2_ff, d2_in;
   logic [47:0]  lo_ff, lo_in, q_ff, q_in;
   logic         sat_ff, sat_in, neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [73:0]  t;
   logic         ge;

   assign n2 = {num[126:0], 1'b0} + 128'(den);
   assign d2 = {den, 1'b0};
   assign sat = n2[127:48] >= 80'(d2);
   assign t = {r_ff, lo_ff[47]};
   assign ge = t >= {1'b0, d2_ff};
   assign done = done_ff;

   always_comb begin
      if (neg_ff) begin
         value = (sat_ff || (q_ff[47] && (q_ff[46:0] != '0))) ? VAL_NEG_MIN : 48'(0) - q_ff;
      end else begin
         value = (sat_ff || q_ff[47]) ? VAL_POS_MAX : q_ff;
      end
   end

   always_comb begin
      r_in = r_ff;
      d2_in = d2_ff;
      lo_in = lo_ff;
      q_in = q_ff;
      sat_in = sat_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         r_in = n2[120:48];
         d2_in = d2;
         lo_in = n2[47:0];
         sat_in = sat;
         neg_in = neg;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in = ge ? 73'(t - {1'b0, d2_ff}) : t[72:0];
         lo_in = {lo_ff[46:0], 1'b0};
         q_in = {q_ff[46:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      r_ff <= r_in;
      d2_ff <= d2_in;
      lo_ff <= lo_in;
      q_ff <= q_in;
      sat_ff <= sat_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

/* rtl/core/p2p1em_back.sv */
// ----------------------------------------------------------------------------
// p2p1em_back
// Entry sequencer: digit multiplier, divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2p1em_back
   import p2p1em_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  elem_type                q_head,
   output logic                    q_pop,
   input  wire logic [31:0]        viscosity,
   input  wire logic signed [31:0] force_x,
   input  wire logic signed [31:0] force_y,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [1:0]              rsp_entry_kind,
   output logic [2:0]              rsp_local_row,
   output logic [2:0]              rsp_local_col,
   output logic signed [47:0]      rsp_value_first,
   output logic signed [47:0]      rsp_value_second,
   output logic                    rsp_last_of_element,
   output logic                    rsp_degenerate
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_OPND  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_NEXT  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   localparam logic [2:0] NDIG_GRAD  = 3'd3;
   localparam logic [2:0] NDIG_VISC  = 3'd5;
   localparam logic [2:0] NDIG_FORCE = 3'd5;
   localparam logic [2:0] NDIG_PHI   = 3'd7;
   localparam logic [2:0] NDIG_RECIP = 3'd4;

   // floor(z/27) as (z * RECIP_27) >> RECIP_SHIFT, exact for z below 2^52
   localparam int          RECIP_SHIFT = 57;
   localparam logic [55:0] RECIP_27 = 56'(((58'd1 << RECIP_SHIFT) / 58'd27) + 58'd1);
   // rounding offsets for divide by 27 and by 27 * 2^27
   localparam logic [4:0]   DIV_BIAS  = 5'd13;
   localparam logic [127:0] LOAD_BIAS = 128'd27 << 26;
   localparam logic [100:0] LOAD_SAT  = 101'd27 << 47;

   logic [2:0]   st_ff, st_in;
   elem_type     el_ff, el_in;
   logic         dg_ff, dg_in, half_ff, half_in, part_ff, part_in, pass_ff, pass_in;
   logic [1:0]   kind_ff, kind_in, q_ff, q_in;
   logic [2:0]   row_ff, row_in, col_ff, col_in, dig_ff, dig_in, ndig_ff, ndig_in;
   logic [55:0]  am_ff, am_in;
   logic [111:0] bm_ff, bm_in;
   logic         psgn_ff, psgn_in, neg_ff, neg_in;
   logic         rcp_ff, rcp_in, rsat_ff, rsat_in;
   logic [127:0] acc_ff, acc_in;
   logic [47:0]  v1_ff, v1_in, v2_ff, v2_in;
   logic         dstart_ff, dstart_in, dneg_ff, dneg_in;
   logic [127:0] dnum_ff, dnum_in;
   logic [71:0]  dden_ff, dden_in;
   logic         ov_ff, ov_in, olast_ff, olast_in, odg_ff, odg_in;
   logic [1:0]   okind_ff, okind_in;
   logic [2:0]   orow_ff, orow_in, ocol_ff, ocol_in;
   logic [47:0]  ov1_ff, ov1_in, ov2_ff, ov2_in;

   logic signed [31:0] fsel;
   logic [31:0]  fmag;
   logic signed [38:0] opx, opy;
   logic [38:0]  mx, my;
   logic signed [38:0] uc [0:2];
   logic signed [38:0] vc [0:2];
   logic signed [41:0] ssum;
   logic [41:0]  smag;
   logic [15:0]  digit;
   logic [71:0]  prod;
   logic [127:0] sh, acc_abs, zsum;
   logic [47:0]  rq, rcp_val, fin_val;
   logic         ofree, last_now, dv_done, fin_now;
   logic [47:0]  dv_value;

   p2p1em_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dstart_ff),
      .num   (dnum_ff),
      .den   (dden_ff),
      .neg   (dneg_ff),
      .done  (dv_done),
      .value (dv_value)
   );

   always_comb begin
      fsel = half_ff ? force_y : force_x;
      fmag = fsel[31] ? (~fsel + 32'd1) : fsel;
      if (part_ff) begin
         opx = gmix(el_ff.a, el_ff.c, G1_TAB[q_ff][row_ff], G0_TAB[q_ff][row_ff]);
         opy = gmix(el_ff.a, el_ff.c, G1_TAB[q_ff][col_ff], G0_TAB[q_ff][col_ff]);
      end else begin
         opx = gmix(el_ff.d, el_ff.b, G0_TAB[q_ff][row_ff], G1_TAB[q_ff][row_ff]);
         opy = gmix(el_ff.d, el_ff.b, G0_TAB[q_ff][col_ff], G1_TAB[q_ff][col_ff]);
      end
      mx = opx[38] ? (~opx + 39'd1) : opx;
      my = opy[38] ? (~opy + 39'd1) : opy;
      for (int k = 0; k < 3; k++) begin
         uc[k] = gmix(el_ff.d, el_ff.b, G0_TAB[k][col_ff], G1_TAB[k][col_ff]);
         vc[k] = gmix(el_ff.a, el_ff.c, G1_TAB[k][col_ff], G0_TAB[k][col_ff]);
      end
      if (half_ff) begin
         ssum = 42'(vc[0]) + 42'(vc[1]) + 42'(vc[2])
              + 42'(vc[row_ff[1:0]]) + 42'(vc[row_ff[1:0]]) + 42'(vc[row_ff[1:0]]);
      end else begin
         ssum = 42'(uc[0]) + 42'(uc[1]) + 42'(uc[2])
              + 42'(uc[row_ff[1:0]]) + 42'(uc[row_ff[1:0]]) + 42'(uc[row_ff[1:0]]);
      end
      smag = ssum[41] ? (~ssum + 42'd1) : ssum;
      digit = bm_ff[{dig_ff, 4'b0000} +: 16];
      prod = 72'(am_ff) * 72'(digit);
      sh = 128'(prod) << {dig_ff, 4'b0000};
      acc_abs = acc_ff[127] ? (~acc_ff + 128'd1) : acc_ff;
      zsum = acc_ff + LOAD_BIAS;
      rq = acc_ff[RECIP_SHIFT +: 48];
      if (rsat_ff) begin
         rcp_val = neg_ff ? VAL_NEG_MIN : VAL_POS_MAX;
      end else begin
         rcp_val = neg_ff ? 48'(0) - rq : rq;
      end
      fin_now = ((st_ff == S_DIV) & dv_done) | ((st_ff == S_NEXT) & rcp_ff);
      fin_val = rcp_ff ? rcp_val : dv_value;
      ofree = ~ov_ff | rsp_pop;
      last_now = dg_ff | ((kind_ff == KIND_LOAD) & (row_ff == 3'd5));
   end

   always_comb begin
      st_in = st_ff;
      el_in = el_ff;
      dg_in = dg_ff;
      half_in = half_ff;
      part_in = part_ff;
      pass_in = pass_ff;
      kind_in = kind_ff;
      q_in = q_ff;
      row_in = row_ff;
      col_in = col_ff;
      dig_in = dig_ff;
      ndig_in = ndig_ff;
      am_in = am_ff;
      bm_in = bm_ff;
      psgn_in = psgn_ff;
      neg_in = neg_ff;
      rcp_in = rcp_ff;
      rsat_in = rsat_ff;
      acc_in = acc_ff;
      v1_in = v1_ff;
      v2_in = v2_ff;
      dstart_in = 1'b0;
      dnum_in = dnum_ff;
      dden_in = dden_ff;
      dneg_in = dneg_ff;
      ov_in = ov_ff & ~rsp_pop;
      okind_in = okind_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      ov1_in = ov1_ff;
      ov2_in = ov2_ff;
      olast_in = olast_ff;
      odg_in = odg_ff;
      q_pop = 1'b0;
      case (st_ff)
         S_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               el_in = q_head;
               dg_in = q_head.degen;
               kind_in = KIND_VISC;
               row_in = '0;
               col_in = '0;
               half_in = 1'b0;
               v1_in = '0;
               v2_in = '0;
               st_in = q_head.degen ? S_EMIT : S_START;
            end
         end
         S_START: begin
            acc_in = '0;
            dig_in = '0;
            pass_in = 1'b0;
            psgn_in = 1'b0;
            rcp_in = 1'b0;
            case (kind_ff)
               KIND_VISC: begin
                  q_in = '0;
                  part_in = 1'b0;
                  st_in = S_OPND;
               end
               KIND_DIV: begin
                  am_in = RECIP_27;
                  bm_in = 112'({smag, DIV_BIAS});
                  ndig_in = NDIG_RECIP;
                  neg_in = ssum[41] ^ el_ff.negd;
                  rcp_in = 1'b1;
                  rsat_in = 1'b0;
                  st_in = S_MUL;
               end
               default: begin
                  am_in = 56'(fmag);
                  bm_in = 112'(el_ff.absd);
                  ndig_in = NDIG_FORCE;
                  neg_in = fsel[31];
                  st_in = S_MUL;
               end
            endcase
         end
         S_OPND: begin
            am_in = 56'(mx);
            bm_in = 112'(my);
            psgn_in = opx[38] ^ opy[38];
            dig_in = '0;
            ndig_in = NDIG_GRAD;
            st_in = S_MUL;
         end
         S_MUL: begin
            acc_in = psgn_ff ? acc_ff - sh : acc_ff + sh;
            dig_in = dig_ff + 1'b1;
            if (dig_ff == ndig_ff - 3'd1) begin
               st_in = S_NEXT;
            end
         end
         S_NEXT: begin
            dig_in = '0;
            psgn_in = 1'b0;
            if (!rcp_ff) begin
               if (kind_ff == KIND_VISC && !pass_ff) begin
                  if (!(q_ff == 2'd2 && part_ff)) begin
                     part_in = ~part_ff;
                     if (part_ff) begin
                        q_in = q_ff + 1'b1;
                     end
                     st_in = S_OPND;
                  end else begin
                     neg_in = acc_ff[127];
                     bm_in = acc_abs[111:0];
                     am_in = 56'(viscosity);
                     ndig_in = NDIG_VISC;
                     acc_in = '0;
                     pass_in = 1'b1;
                     st_in = S_MUL;
                  end
               end else if (kind_ff == KIND_VISC) begin
                  dnum_in = acc_ff << 5;
                  dden_in = 72'(el_ff.absd) * 72'd27;
                  dneg_in = neg_ff;
                  dstart_in = 1'b1;
                  st_in = S_DIV;
               end else if (!pass_ff) begin
                  bm_in = acc_ff[111:0];
                  am_in = 56'(PHIS_TAB[row_ff]);
                  ndig_in = NDIG_PHI;
                  acc_in = '0;
                  pass_in = 1'b1;
                  st_in = S_MUL;
               end else begin
                  bm_in = 112'(zsum[78:27]);
                  am_in = RECIP_27;
                  ndig_in = NDIG_RECIP;
                  rsat_in = zsum[127:27] >= LOAD_SAT;
                  acc_in = '0;
                  rcp_in = 1'b1;
                  st_in = S_MUL;
               end
            end
         end
         S_DIV: ;
         S_EMIT: begin
            if (ofree) begin
               ov_in = 1'b1;
               okind_in = kind_ff;
               orow_in = row_ff;
               ocol_in = col_ff;
               ov1_in = v1_ff;
               ov2_in = v2_ff;
               olast_in = last_now;
               odg_in = dg_ff;
               half_in = 1'b0;
               if (last_now) begin
                  st_in = S_LOAD;
               end else begin
                  st_in = S_START;
                  case (kind_ff)
                     KIND_VISC: begin
                        if (col_ff == 3'd5) begin
                           col_in = '0;
                           if (row_ff == 3'd5) begin
                              row_in = '0;
                              kind_in = KIND_DIV;
                           end else begin
                              row_in = row_ff + 1'b1;
                           end
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                     KIND_DIV: begin
                        if (col_ff == 3'd5) begin
                           col_in = '0;
                           if (row_ff == 3'd2) begin
                              row_in = '0;
                              kind_in = KIND_LOAD;
                           end else begin
                              row_in = row_ff + 1'b1;
                           end
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                     default: begin
                        row_in = row_ff + 1'b1;
                     end
                  endcase
               end
            end
         end
         default: begin
            st_in = S_LOAD;
         end
      endcase
      // value ready from the divider or the reciprocal pass
      if (fin_now) begin
         if (kind_ff == KIND_VISC) begin
            v1_in = fin_val;
            v2_in = fin_val;
            st_in = S_EMIT;
         end else if (!half_ff) begin
            v1_in = fin_val;
            half_in = 1'b1;
            st_in = S_START;
         end else begin
            v2_in = fin_val;
            st_in = S_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD;
         dstart_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         dstart_ff <= dstart_in;
         ov_ff <= ov_in;
      end
      el_ff <= el_in;
      dg_ff <= dg_in;
      half_ff <= half_in;
      part_ff <= part_in;
      pass_ff <= pass_in;
      kind_ff <= kind_in;
      q_ff <= q_in;
      row_ff <= row_in;
      col_ff <= col_in;
      dig_ff <= dig_in;
      ndig_ff <= ndig_in;
      am_ff <= am_in;
      bm_ff <= bm_in;
      psgn_ff <= psgn_in;
      neg_ff <= neg_in;
      rcp_ff <= rcp_in;
      rsat_ff <= rsat_in;
      acc_ff <= acc_in;
      v1_ff <= v1_in;
      v2_ff <= v2_in;
      dnum_ff <= dnum_in;
      dden_ff <= dden_in;
      dneg_ff <= dneg_in;
      okind_ff <= okind_in;
      orow_ff <= orow_in;
      ocol_ff <= ocol_in;
      ov1_ff <= ov1_in;
      ov2_ff <= ov2_in;
      olast_ff <= olast_in;
      odg_ff <= odg_in;
   end

   assign rsp_empty = ~ov_ff;
   assign rsp_entry_kind = okind_ff;
   assign rsp_local_row = orow_ff;
   assign rsp_local_col = ocol_ff;
   assign rsp_value_first = ov1_ff;
   assign rsp_value_second = ov2_ff;
   assign rsp_last_of_element = olast_ff;
   assign rsp_degenerate = odg_ff;

endmodule

`default_nettype wire

/* rtl/core/p2p1_triangle_element_matrices_core.sv */
// Each triangle is worked through by the serial divider and the shared 56x16
// digit multiplier; a flat triangle skips both. Triangles keep entering a
// 4-deep queue. Reset (synchronous, active high) empties queue and result
// register and loads viscosity 1.0, force 1.0.
// ----------------------------------------------------------------------------
// p2p1_triangle_element_matrices_core
// P2-P1 triangle element matrices: front queue, entry back end, registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2p1_triangle_element_matrices_core
   import p2p1em_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic signed [31:0] req_corner0_x,
   input  wire logic signed [31:0] req_corner0_y,
   input  wire logic signed [31:0] req_corner1_x,
   input  wire logic signed [31:0] req_corner1_y,
   input  wire logic signed [31:0] req_corner2_x,
   input  wire logic signed [31:0] req_corner2_y,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [1:0]              rsp_entry_kind,
   output logic [2:0]              rsp_local_row,
   output logic [2:0]              rsp_local_col,
   output logic signed [47:0]      rsp_value_first,
   output logic signed [47:0]      rsp_value_second,
   output logic                    rsp_last_of_element,
   output logic                    rsp_degenerate,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   logic [31:0] visc_ff, visc_in, fx_ff, fx_in, fy_ff, fy_in;
   logic        q_empty, q_pop;
   elem_type    q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      visc_in = visc_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_VISCOSITY: visc_in = csr_wdata;
            REG_FORCE_X:   fx_in = csr_wdata;
            REG_FORCE_Y:   fy_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visc_ff <= RESET_VISCOSITY;
         fx_ff <= RESET_FORCE;
         fy_ff <= RESET_FORCE;
      end else begin
         visc_ff <= visc_in;
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
   end

   p2p1em_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_corner0_x (req_corner0_x),
      .req_corner0_y (req_corner0_y),
      .req_corner1_x (req_corner1_x),
      .req_corner1_y (req_corner1_y),
      .req_corner2_x (req_corner2_x),
      .req_corner2_y (req_corner2_y),
      .q_pop         (q_pop),
      .q_empty       (q_empty),
      .q_head        (q_head)
   );

   p2p1em_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .viscosity           (visc_ff),
      .force_x             (signed'(fx_ff)),
      .force_y             (signed'(fy_ff)),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_entry_kind      (rsp_entry_kind),
      .rsp_local_row       (rsp_local_row),
      .rsp_local_col       (rsp_local_col),
      .rsp_value_first     (rsp_value_first),
      .rsp_value_second    (rsp_value_second),
      .rsp_last_of_element (rsp_last_of_element),
      .rsp_degenerate      (rsp_degenerate)
   );

endmodule

`default_nettype wire

/* rtl/core/p2p1em_checker.sv */
// ----------------------------------------------------------------------------
// p2p1em_checker
// Port-level checks of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "p2p1_triangle_element_matrices_core_defines.svh"

module p2p1em_checker
   import p2p1em_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic [1:0]         rsp_entry_kind,
   input wire logic [2:0]         rsp_local_row,
   input wire logic signed [47:0] rsp_value_first,
   input wire logic signed [47:0] rsp_value_second,
   input wire logic               rsp_last_of_element,
   input wire logic               rsp_degenerate
);

   // a waiting result stays until transferred
   `P2P1_ASSERT_NXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty)

   `P2P1_ASSERT_IMP(a_degen_alone, !rsp_empty && rsp_degenerate, rsp_last_of_element && rsp_value_first == 48'sd0 && rsp_value_second == 48'sd0)

   `P2P1_ASSERT_IMP(a_visc_pair, !rsp_empty && rsp_entry_kind == KIND_VISC, rsp_value_first == rsp_value_second)

   `P2P1_ASSERT_IMP(a_last_load, !rsp_empty && rsp_last_of_element && !rsp_degenerate, rsp_entry_kind == KIND_LOAD && rsp_local_row == 3'd5)

endmodule

bind p2p1_triangle_element_matrices_core p2p1em_checker u_checker (.*);

`default_nettype wire

/* verif/tb_p2p1_triangle_element_matrices_core.sv */
// ----------------------------------------------------------------------------
// tb_p2p1_triangle_element_matrices_core
// Self-checking bench for the triangle element matrices core: drives
// triangles and register writes, predicts all 60 entries (or the single
// degenerate entry) per triangle with exact wide integer arithmetic and
// checks every popped entry field by field under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_p2p1_triangle_element_matrices_core;
   import p2p1em_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int RANDOM_PER_PHASE = 75;

   typedef logic signed [191:0] wide_t;

   typedef struct packed {
      logic signed [31:0] x0, y0, x1, y1, x2, y2;
   } triangle_t;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [47:0] first;
      logic [47:0] second;
      logic        last;
      logic        degen;
   } entry_t;

   class element_scoreboard;
      logic [31:0] viscosity;
      logic [31:0] force_x;
      logic [31:0] force_y;
      entry_t      expected[$];
      int          errors;

      function new();
         viscosity = RESET_VISCOSITY;
         force_x   = RESET_FORCE;
         force_y   = RESET_FORCE;
         errors    = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_VISCOSITY: viscosity = val;
            REG_FORCE_X:   force_x = val;
            REG_FORCE_Y:   force_y = val;
            default: ;
         endcase
      endfunction

      function logic [47:0] clamp48(bit neg, wide_t mag);
         if (neg) begin
            if (mag > (wide_t'(1) <<< 47)) return VAL_NEG_MIN;
            return 48'(-mag);
         end
         if (mag > wide_t'(VAL_POS_MAX)) return VAL_POS_MAX;
         return mag[47:0];
      endfunction

      function wide_t round_div(wide_t num, wide_t den);
         return (2 * num + den) / (2 * den);
      endfunction

      function wide_t magnitude(wide_t x);
         return x < 0 ? -x : x;
      endfunction

      function void push_entry(logic [1:0] kind, int row, int col, logic [47:0] v1,
                               logic [47:0] v2, bit last, bit degen);
         entry_t e;
         e.kind = kind;
         e.row = 3'(row);
         e.col = 3'(col);
         e.first = v1;
         e.second = v2;
         e.last = last;
         e.degen = degen;
         expected.push_back(e);
      endfunction

      function void note_triangle(triangle_t t);
         int     pts[3][3] = '{'{4, 1, 1}, '{1, 4, 1}, '{1, 1, 4}};
         int     lgrad[3][2] = '{'{-1, -1}, '{1, 0}, '{0, 1}};
         int     edges[3][2] = '{'{0, 1}, '{1, 2}, '{2, 0}};
         longint a, b, c, d, fx, fy, sx, sy;
         longint u[3][6], v[3][6], phis[6], g[6][2];
         wide_t  det, absd, n, w_visc, kden, fden;
         bit     negd;
         int     i, j, k, q, m;
         a = longint'(t.x1) - longint'(t.x0);
         c = longint'(t.y1) - longint'(t.y0);
         b = longint'(t.x2) - longint'(t.x0);
         d = longint'(t.y2) - longint'(t.y0);
         det = wide_t'(a) * wide_t'(d) - wide_t'(b) * wide_t'(c);
         if (det == 0) begin
            push_entry(KIND_VISC, 0, 0, '0, '0, 1'b1, 1'b1);
            return;
         end
         negd = det < 0;
         absd = magnitude(det);
         for (i = 0; i < 6; i++) phis[i] = 0;
         for (q = 0; q < 3; q++) begin
            for (k = 0; k < 3; k++) begin
               for (m = 0; m < 2; m++) g[k][m] = (4 * pts[q][k] - 6) * lgrad[k][m];
               phis[k] += pts[q][k] * (2 * pts[q][k] - 6);
               i = edges[k][0];
               j = edges[k][1];
               for (m = 0; m < 2; m++)
                  g[3+k][m] = 4 * (pts[q][j] * lgrad[i][m] + pts[q][i] * lgrad[j][m]);
               phis[3+k] += 4 * pts[q][i] * pts[q][j];
            end
            for (i = 0; i < 6; i++) begin
               u[q][i] = d * g[i][0] - b * g[i][1];
               v[q][i] = a * g[i][1] - c * g[i][0];
            end
         end
         w_visc = 0;
         w_visc[31:0] = viscosity;
         kden = absd * 27;
         for (i = 0; i < 6; i++)
            for (j = 0; j < 6; j++) begin
               n = 0;
               for (q = 0; q < 3; q++)
                  n += wide_t'(u[q][i]) * wide_t'(u[q][j]) + wide_t'(v[q][i]) * wide_t'(v[q][j]);
               push_entry(KIND_VISC, i, j,
                  clamp48(n < 0, round_div(magnitude(n) * w_visc * 32, kden)),
                  clamp48(n < 0, round_div(magnitude(n) * w_visc * 32, kden)), 1'b0, 1'b0);
            end
         for (j = 0; j < 3; j++)
            for (i = 0; i < 6; i++) begin
               sx = 0;
               sy = 0;
               for (q = 0; q < 3; q++) begin
                  sx += pts[q][j] * u[q][i];
                  sy += pts[q][j] * v[q][i];
               end
               push_entry(KIND_DIV, j, i,
                  clamp48((sx < 0) != negd, (magnitude(wide_t'(sx)) * 64 + 27) / 54),
                  clamp48((sy < 0) != negd, (magnitude(wide_t'(sy)) * 64 + 27) / 54),
                  1'b0, 1'b0);
            end
         fx = longint'(signed'(force_x));
         fy = longint'(signed'(force_y));
         fden = wide_t'(27) <<< 27;
         for (i = 0; i < 6; i++)
            push_entry(KIND_LOAD, i, 0,
               clamp48((fx < 0) != (phis[i] < 0), round_div(absd * magnitude(wide_t'(fx))
                  * magnitude(wide_t'(phis[i])), fden)),
               clamp48((fy < 0) != (phis[i] < 0), round_div(absd * magnitude(wide_t'(fy))
                  * magnitude(wide_t'(phis[i])), fden)),
               i == 5, 1'b0);
      endfunction

      function void compare(string field, logic [47:0] want, logic [47:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t mismatch %s: expected %h actual %h", $time, field, want, got);
         end
      endfunction

      function void check(entry_t got);
         entry_t want;
         if (expected.size() == 0) begin
            errors++;
            $display("%0t unexpected entry: expected none actual %h", $time, got);
            return;
         end
         want = expected.pop_front();
         compare("entry_kind", 48'(want.kind), 48'(got.kind));
         compare("local_row", 48'(want.row), 48'(got.row));
         compare("local_col", 48'(want.col), 48'(got.col));
         compare("value_first", want.first, got.first);
         compare("value_second", want.second, got.second);
         compare("last_of_element", 48'(want.last), 48'(got.last));
         compare("degenerate", 48'(want.degen), 48'(got.degen));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic signed [31:0] req_corner0_x = '0;
   logic signed [31:0] req_corner0_y = '0;
   logic signed [31:0] req_corner1_x = '0;
   logic signed [31:0] req_corner1_y = '0;
   logic signed [31:0] req_corner2_x = '0;
   logic signed [31:0] req_corner2_y = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [1:0]         rsp_entry_kind;
   logic [2:0]         rsp_local_row;
   logic [2:0]         rsp_local_col;
   logic signed [47:0] rsp_value_first;
   logic signed [47:0] rsp_value_second;
   logic               rsp_last_of_element;
   logic               rsp_degenerate;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   element_scoreboard sb = new();
   int tx_idle_pct = 16;
   int rx_idle_pct = 65;
   int hold_cycles = 0;
   int cycles = 0;

   p2p1_triangle_element_matrices_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: check each transfer, then choose the next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check({rsp_entry_kind, rsp_local_row, rsp_local_col, rsp_value_first,
                   rsp_value_second, rsp_last_of_element, rsp_degenerate});
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= $urandom_range(99) >= rx_idle_pct;
      end
   end

   task automatic push_triangle(triangle_t t);
      req_push <= 1'b1;
      req_corner0_x <= t.x0;
      req_corner0_y <= t.y0;
      req_corner1_x <= t.x1;
      req_corner1_y <= t.y1;
      req_corner2_x <= t.x2;
      req_corner2_y <= t.y2;
      do @(posedge clock); while (req_full);
      sb.note_triangle(t);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   function automatic triangle_t random_triangle();
      triangle_t t;
      logic signed [31:0] bx, by;
      case ($urandom_range(9))
         0: t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         1: begin
            bx = $urandom_range(0, 1 << 20) - (1 << 19);
            by = $urandom_range(0, 1 << 20) - (1 << 19);
            t.x0 = bx;
            t.y0 = by;
            t.x1 = bx + $urandom_range(0, 1 << 18) - (1 << 17);
            t.y1 = by + $urandom_range(0, 1 << 18) - (1 << 17);
            t.x2 = $urandom_range(1) ? t.x0 : 2 * t.x1 - t.x0;
            t.y2 = t.x2 == t.x0 ? t.y0 : 2 * t.y1 - t.y0;
         end
         default: begin
            bx = $signed($urandom) >>> $urandom_range(1, 12);
            by = $signed($urandom) >>> $urandom_range(1, 12);
            t.x0 = bx;
            t.y0 = by;
            t.x1 = bx + $urandom_range(0, 1 << 19) - (1 << 18);
            t.y1 = by + $urandom_range(0, 1 << 19) - (1 << 18);
            t.x2 = bx + $urandom_range(0, 1 << 19) - (1 << 18);
            t.y2 = by + $urandom_range(0, 1 << 19) - (1 << 18);
         end
      endcase
      return t;
   endfunction

   task automatic directed_triangles();
      triangle_t list[9];
      list[0] = {32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0, 32'sh10000};
      list[1] = {32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh0};
      list[2] = '0;
      list[3] = {32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 32'sh30000, 32'sh30000};
      list[4] = {32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                 32'sh80000000, 32'sh7FFFFFFF};
      list[5] = {32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                 32'sh7FFFFFFF, 32'sh80000000};
      list[6] = {32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh1};
      list[7] = {32'sh7FFF0000, 32'sh7FFF0000, 32'sh7FFFFFFF, 32'sh7FFF0000,
                 32'sh7FFF0000, 32'sh7FFFFFFF};
      list[8] = {32'sh0, 32'sh0, 32'sh7FFFFFFF, 32'sh0, 32'sh0, 32'sh1};
      foreach (list[i]) push_triangle(list[i]);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         tx_idle_pct = phase < 2 ? 16 : (phase < 4 ? 65 : 0);
         rx_idle_pct = phase < 2 ? 65 : (phase < 4 ? 16 : 0);
         case (phase)
            1: begin
               write_reg(REG_VISCOSITY, 32'hFFFF_FFFF);
               write_reg(REG_FORCE_X, 32'h7FFF_FFFF);
               write_reg(REG_FORCE_Y, 32'h8000_0000);
            end
            2: begin
               write_reg(REG_VISCOSITY, 32'h0);
               write_reg(REG_FORCE_X, 32'h0);
               write_reg(REG_FORCE_Y, 32'hFFFF_0000);
               write_reg(REG_UNUSED, 32'hDEAD_BEEF);
            end
            4: begin
               write_reg(REG_VISCOSITY, 32'h1);
               write_reg(REG_FORCE_X, 32'hFFFF_FFFF);
               write_reg(REG_FORCE_Y, 32'h7FFF_FFFF);
               hold_cycles = 20000;
            end
            3, 5: begin
               write_reg(REG_VISCOSITY, $urandom_range(0, 32'h0010_0000));
               write_reg(REG_FORCE_X, $urandom);
               write_reg(REG_FORCE_Y, $urandom);
            end
            default: ;
         endcase
         if (phase < 2) directed_triangles();
         for (int n = 0; n < RANDOM_PER_PHASE; n++) push_triangle(random_triangle());
         req_push <= 1'b0;
      end
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/p2p1em_pkg.sv
rtl/core/p2p1em_front.sv
rtl/core/p2p1em_div.sv
rtl/core/p2p1em_back.sv
rtl/core/p2p1_triangle_element_matrices_core.sv
rtl/core/p2p1em_checker.sv
verif/tb_p2p1_triangle_element_matrices_core.sv
